>>> rtl/length_prefixed_key_compare_core_assert.svh
// Assertion macros shared by the RTL.
`ifndef LENGTH_PREFIXED_KEY_COMPARE_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_KEY_COMPARE_CORE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define LPKC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpkc assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define LPKC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpkc assertion failed");

`endif

>>> rtl/lpkc_pkg.sv
package lpkc_pkg;

    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int BYTE_WIDTH       = 8;

    localparam logic OP_START = 1'b0;
    localparam logic OP_PAIR  = 1'b1;

    localparam logic [1:0] ORDER_EQ = 2'b00;
    localparam logic [1:0] ORDER_GT = 2'b01;
    localparam logic [1:0] ORDER_LT = 2'b11;

    typedef enum logic [2:0] {
        CAUSE_ABSENT   = 3'd0,
        CAUSE_INFINITE = 3'd1,
        CAUSE_BYTE     = 3'd2,
        CAUSE_LENGTH   = 3'd3,
        CAUSE_EQUAL    = 3'd4
    } t_cause;

    typedef struct packed {
        logic       busy;
        logic [1:0] byte_verdict;
        logic [1:0] length_verdict;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [1:0] order;
        t_cause     cause;
    } t_result;

endpackage

>>> rtl/lpkc_eval.sv
module lpkc_eval #(
    parameter int LENGTH_WIDTH = lpkc_pkg::LENGTH_WIDTH_DEF
) (
    input  lpkc_pkg::t_state                  i_state,
    input  logic                              i_opcode,
    input  logic                              i_first_present,
    input  logic                              i_second_present,
    input  logic [LENGTH_WIDTH-1:0]           i_first_length,
    input  logic [LENGTH_WIDTH-1:0]           i_second_length,
    input  logic [lpkc_pkg::BYTE_WIDTH-1:0]   i_first_byte,
    input  logic [lpkc_pkg::BYTE_WIDTH-1:0]   i_second_byte,
    input  logic                              i_last_pair,
    output lpkc_pkg::t_state                  o_state,
    output lpkc_pkg::t_result                 o_result
);

    logic       len_lt;
    logic       len_gt;
    logic [1:0] len_v;
    logic [1:0] byte_v;

    assign len_lt = i_first_length < i_second_length;
    assign len_gt = i_first_length > i_second_length;
    assign len_v  = len_lt ? lpkc_pkg::ORDER_LT :
                    (len_gt ? lpkc_pkg::ORDER_GT : lpkc_pkg::ORDER_EQ);

    always_comb begin
        byte_v = i_state.byte_verdict;
        if (i_state.byte_verdict == lpkc_pkg::ORDER_EQ && i_first_byte != i_second_byte) begin
            byte_v = (i_first_byte < i_second_byte) ? lpkc_pkg::ORDER_LT : lpkc_pkg::ORDER_GT;
        end
    end

    always_comb begin
        o_state        = i_state;
        o_result.valid = 1'b0;
        o_result.order = lpkc_pkg::ORDER_EQ;
        o_result.cause = lpkc_pkg::CAUSE_EQUAL;
        if (i_opcode == lpkc_pkg::OP_START) begin
            o_state.busy           = 1'b0;
            o_state.byte_verdict   = lpkc_pkg::ORDER_EQ;
            o_state.length_verdict = lpkc_pkg::ORDER_EQ;
            o_result.valid         = 1'b1;
            if (!i_first_present && !i_second_present) begin
                o_result.cause = lpkc_pkg::CAUSE_ABSENT;
            end else if (!i_first_present) begin
                o_result.order = lpkc_pkg::ORDER_LT;
                o_result.cause = lpkc_pkg::CAUSE_ABSENT;
            end else if (!i_second_present) begin
                o_result.order = lpkc_pkg::ORDER_GT;
                o_result.cause = lpkc_pkg::CAUSE_ABSENT;
            end else if (&i_first_length) begin
                o_result.order = lpkc_pkg::ORDER_GT;
                o_result.cause = lpkc_pkg::CAUSE_INFINITE;
            end else if (&i_second_length) begin
                o_result.order = lpkc_pkg::ORDER_LT;
                o_result.cause = lpkc_pkg::CAUSE_INFINITE;
            end else begin
                o_state.length_verdict = len_v;
                if (i_first_length == '0 || i_second_length == '0) begin
                    o_result.order = len_v;
                    o_result.cause = (len_v != lpkc_pkg::ORDER_EQ) ?
                                     lpkc_pkg::CAUSE_LENGTH : lpkc_pkg::CAUSE_EQUAL;
                end else begin
                    o_state.busy   = 1'b1;
                    o_result.valid = 1'b0;
                end
            end
        end else if (i_state.busy) begin
            o_state.byte_verdict = byte_v;
            if (i_last_pair) begin
                o_state.busy   = 1'b0;
                o_result.valid = 1'b1;
                if (byte_v != lpkc_pkg::ORDER_EQ) begin
                    o_result.order = byte_v;
                    o_result.cause = lpkc_pkg::CAUSE_BYTE;
                end else if (i_state.length_verdict != lpkc_pkg::ORDER_EQ) begin
                    o_result.order = i_state.length_verdict;
                    o_result.cause = lpkc_pkg::CAUSE_LENGTH;
                end
            end
        end
    end

endmodule

>>> rtl/length_prefixed_key_compare_core.sv
// Channel | Dir | Signals                                            | Contents
// s       | in  | i_s_tvalid/o_s_tready/i_s_tdata/i_s_tuser/i_s_tlast | header or byte pair
// m       | out | o_m_tvalid/i_m_tready/o_m_tdata                    | order and cause
// One transaction per cycle is sustained on the input channel while the output is not stalled.
// An accepted input is held in the input register, and any result it yields is then loaded
// into the result register, which drives the output channel.
// The input register advances when the result register is empty or being taken;
// a stalled output holds both stages and, once the input register is full, drops o_s_tready.
// Reset (synchronous, i_rst_n low) closes any open comparison and empties both stages.
`include "length_prefixed_key_compare_core_assert.svh"

module length_prefixed_key_compare_core #(
    parameter int LENGTH_WIDTH = lpkc_pkg::LENGTH_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // lsb up: first_present, second_present, first_length, second_length,
    // first_byte, second_byte, zero fill
    input  logic [((2*LENGTH_WIDTH+2*lpkc_pkg::BYTE_WIDTH+2+7)/8)*8-1:0] i_s_tdata,
    input  logic i_s_tuser,   // opcode
    input  logic i_s_tlast,   // last_pair
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // lsb up: order[1:0], cause[4:2], zero fill
    output logic [7:0] o_m_tdata
);

    localparam int BW      = lpkc_pkg::BYTE_WIDTH;
    localparam int L1_LSB  = 2;
    localparam int L2_LSB  = 2 + LENGTH_WIDTH;
    localparam int B1_LSB  = 2 + 2*LENGTH_WIDTH;
    localparam int B2_LSB  = 2 + 2*LENGTH_WIDTH + BW;

    logic                    r_in_vld;
    logic                    r_op;
    logic                    r_fp;
    logic                    r_sp;
    logic [LENGTH_WIDTH-1:0] r_l1;
    logic [LENGTH_WIDTH-1:0] r_l2;
    logic [BW-1:0]           r_b1;
    logic [BW-1:0]           r_b2;
    logic                    r_last;

    lpkc_pkg::t_state  r_state;
    lpkc_pkg::t_state  n_state;
    lpkc_pkg::t_result res;

    logic               r_out_vld;
    logic [1:0]         r_out_order;
    lpkc_pkg::t_cause   r_out_cause;

    logic out_free;
    logic advance;
    logic take_in;

    assign out_free   = !r_out_vld || i_m_tready;
    assign advance    = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || out_free;
    assign take_in    = i_s_tvalid && o_s_tready;

    lpkc_eval #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_eval (
        .i_state         (r_state),
        .i_opcode        (r_op),
        .i_first_present (r_fp),
        .i_second_present(r_sp),
        .i_first_length  (r_l1),
        .i_second_length (r_l2),
        .i_first_byte    (r_b1),
        .i_second_byte   (r_b2),
        .i_last_pair     (r_last),
        .o_state         (n_state),
        .o_result        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take_in) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_op   <= i_s_tuser;
            r_fp   <= i_s_tdata[0];
            r_sp   <= i_s_tdata[1];
            r_l1   <= i_s_tdata[L1_LSB +: LENGTH_WIDTH];
            r_l2   <= i_s_tdata[L2_LSB +: LENGTH_WIDTH];
            r_b1   <= i_s_tdata[B1_LSB +: BW];
            r_b2   <= i_s_tdata[B2_LSB +: BW];
            r_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.busy           <= 1'b0;
            r_state.byte_verdict   <= lpkc_pkg::ORDER_EQ;
            r_state.length_verdict <= lpkc_pkg::ORDER_EQ;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= res.valid;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out_order <= res.order;
            r_out_cause <= res.cause;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out_cause, r_out_order};

    `LPKC_ASSERT_IMPL(a_byte_cause_signed,
        o_m_tvalid && r_out_cause == lpkc_pkg::CAUSE_BYTE,
        r_out_order != lpkc_pkg::ORDER_EQ)
    `LPKC_ASSERT_IMPL(a_equal_cause_zero,
        o_m_tvalid && r_out_cause == lpkc_pkg::CAUSE_EQUAL,
        r_out_order == lpkc_pkg::ORDER_EQ)
    `LPKC_ASSERT_IMPL(a_length_cause_signed,
        o_m_tvalid && r_out_cause == lpkc_pkg::CAUSE_LENGTH,
        r_out_order != lpkc_pkg::ORDER_EQ)
    `LPKC_ASSERT_NEXT(a_idle_pair_ignored,
        advance && r_op == lpkc_pkg::OP_PAIR && !r_state.busy,
        !r_state.busy)
    `LPKC_ASSERT_NEXT(a_start_always_answers_or_opens,
        advance && r_op == lpkc_pkg::OP_START,
        r_state.busy || r_out_vld)

endmodule

>>> tb/tb.sv
module tb;

    localparam int LW     = lpkc_pkg::LENGTH_WIDTH_DEF;
    localparam int BYTE_W = lpkc_pkg::BYTE_WIDTH;
    localparam int DATA_W = ((2*LW + 2*BYTE_W + 2 + 7) / 8) * 8;

    typedef struct packed {
        logic             op;
        logic             first_present;
        logic             second_present;
        logic [LW-1:0]    first_length;
        logic [LW-1:0]    second_length;
        logic [7:0]       first_byte;
        logic [7:0]       second_byte;
        logic             last_pair;
    } t_key_item;

    typedef struct packed {
        logic [1:0]       order;
        lpkc_pkg::t_cause cause;
    } t_verdict;

    typedef struct packed {
        t_key_item it;
        logic      typed;
        t_verdict  want;
    } t_dir_row;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata  = '0;  // lsb up: first_present, second_present,
                                         // first_length, second_length, first_byte,
                                         // second_byte, zero fill
    logic              i_s_tuser  = 1'b0; // opcode
    logic              i_s_tlast  = 1'b0; // last_pair
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [7:0]        o_m_tdata;         // lsb up: order[1:0], cause[4:2], zero fill

    length_prefixed_key_compare_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic       cmp_open     = 1'b0;
    logic [1:0] byte_order_q = lpkc_pkg::ORDER_EQ;
    logic [1:0] len_order_q  = lpkc_pkg::ORDER_EQ;

    t_verdict   order_q[$];
    int         fail_cnt       = 0;
    int         src_idle_pct   = 29;
    int         sink_idle_pct  = 29;
    bit         sink_hold_req  = 1'b0;
    int         sink_hold_left = 0;

    function automatic bit predict_key_order(input t_key_item it, output t_verdict v);
        logic [LW-1:0] shorter;
        v = '0;
        if (it.op == lpkc_pkg::OP_START) begin
            cmp_open     = 1'b0;
            byte_order_q = lpkc_pkg::ORDER_EQ;
            len_order_q  = lpkc_pkg::ORDER_EQ;
            v.cause      = lpkc_pkg::CAUSE_ABSENT;
            if (!it.first_present && !it.second_present) begin
                v.order = lpkc_pkg::ORDER_EQ;
                return 1'b1;
            end
            if (!it.first_present) begin
                v.order = lpkc_pkg::ORDER_LT;
                return 1'b1;
            end
            if (!it.second_present) begin
                v.order = lpkc_pkg::ORDER_GT;
                return 1'b1;
            end
            v.cause = lpkc_pkg::CAUSE_INFINITE;
            if (it.first_length == '1) begin
                v.order = lpkc_pkg::ORDER_GT;
                return 1'b1;
            end
            if (it.second_length == '1) begin
                v.order = lpkc_pkg::ORDER_LT;
                return 1'b1;
            end
            len_order_q = (it.first_length < it.second_length) ? lpkc_pkg::ORDER_LT :
                          (it.first_length > it.second_length) ? lpkc_pkg::ORDER_GT :
                                                                 lpkc_pkg::ORDER_EQ;
            shorter = (it.first_length < it.second_length) ? it.first_length
                                                           : it.second_length;
            if (shorter == '0) begin
                v.order = len_order_q;
                v.cause = (len_order_q != lpkc_pkg::ORDER_EQ) ? lpkc_pkg::CAUSE_LENGTH
                                                              : lpkc_pkg::CAUSE_EQUAL;
                return 1'b1;
            end
            cmp_open = 1'b1;
            return 1'b0;
        end
        if (!cmp_open)
            return 1'b0;
        if (byte_order_q == lpkc_pkg::ORDER_EQ && it.first_byte != it.second_byte)
            byte_order_q = (it.first_byte < it.second_byte) ? lpkc_pkg::ORDER_LT
                                                            : lpkc_pkg::ORDER_GT;
        if (!it.last_pair)
            return 1'b0;
        cmp_open = 1'b0;
        if (byte_order_q != lpkc_pkg::ORDER_EQ) begin
            v.order = byte_order_q;
            v.cause = lpkc_pkg::CAUSE_BYTE;
        end else if (len_order_q != lpkc_pkg::ORDER_EQ) begin
            v.order = len_order_q;
            v.cause = lpkc_pkg::CAUSE_LENGTH;
        end else begin
            v.order = lpkc_pkg::ORDER_EQ;
            v.cause = lpkc_pkg::CAUSE_EQUAL;
        end
        return 1'b1;
    endfunction

    function automatic t_key_item start_item(int p1, int p2, int l1, int l2);
        t_key_item it;
        it.op             = lpkc_pkg::OP_START;
        it.first_present  = p1[0];
        it.second_present = p2[0];
        it.first_length   = l1[LW-1:0];
        it.second_length  = l2[LW-1:0];
        it.first_byte     = 8'($urandom);
        it.second_byte    = 8'($urandom);
        it.last_pair      = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_key_item pair_item(int b1, int b2, int last);
        t_key_item it;
        it.op             = lpkc_pkg::OP_PAIR;
        it.first_present  = 1'($urandom_range(1));
        it.second_present = 1'($urandom_range(1));
        it.first_length   = LW'($urandom);
        it.second_length  = LW'($urandom);
        it.first_byte     = b1[7:0];
        it.second_byte    = b2[7:0];
        it.last_pair      = last[0];
        return it;
    endfunction

    function automatic t_dir_row mk_row(t_key_item it, int typed, logic [1:0] order,
                                        lpkc_pkg::t_cause cause);
        t_dir_row r;
        r.it         = it;
        r.typed      = typed[0];
        r.want.order = order;
        r.want.cause = cause;
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input t_key_item it, input logic typed, input t_verdict want);
        logic [DATA_W-1:0] d;
        t_verdict          v;
        bit                has;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        d                          = '0;
        d[0]                       = it.first_present;
        d[1]                       = it.second_present;
        d[2 +: LW]                 = it.first_length;
        d[2+LW +: LW]              = it.second_length;
        d[2+2*LW +: BYTE_W]        = it.first_byte;
        d[2+2*LW+BYTE_W +: BYTE_W] = it.second_byte;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= it.op;
        i_s_tlast  <= it.last_pair;
        do @(posedge i_clk); while (!o_s_tready);
        has = predict_key_order(it, v);
        if (typed)
            order_q.push_back(want);
        else if (has)
            order_q.push_back(v);
        @(negedge i_clk);
    endtask

    task automatic report_fail(input string what, input t_verdict want, input logic [7:0] got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%s: expected order %b cause %0d, got order %b cause %0d",
                     what, want.order, want.cause, got[1:0], got[4:2]);
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (order_q.size() == 0) begin
                report_fail("unexpected transaction", '0, o_m_tdata);
            end else begin
                want = order_q.pop_front();
                if (o_m_tdata[1:0] !== want.order || o_m_tdata[4:2] !== want.cause)
                    report_fail("mismatch", want, o_m_tdata);
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                i_m_tready <= 1'b0;
            end else if (sink_hold_req && !hold_taken) begin
                hold_taken     = 1'b1;
                sink_hold_left = 400;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        #(12 * 200000);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        t_dir_row      dir_rows[$];
        int            items_sent;
        int            kind;
        int            n;
        int            diff_at;
        int            k;
        bit            hold_done;
        logic [LW-1:0] la;
        logic [LW-1:0] lb;
        logic [7:0]    ba;
        logic [7:0]    bb;

        items_sent = 0;
        hold_done  = 1'b0;

        dir_rows.push_back(mk_row(start_item(0, 0, 5, 7), 1, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_ABSENT));
        dir_rows.push_back(mk_row(start_item(0, 1, 0, '1), 1, lpkc_pkg::ORDER_LT,
                                  lpkc_pkg::CAUSE_ABSENT));
        dir_rows.push_back(mk_row(start_item(1, 0, '1, 0), 1, lpkc_pkg::ORDER_GT,
                                  lpkc_pkg::CAUSE_ABSENT));
        dir_rows.push_back(mk_row(start_item(1, 1, '1, '1), 1, lpkc_pkg::ORDER_GT,
                                  lpkc_pkg::CAUSE_INFINITE));
        dir_rows.push_back(mk_row(start_item(1, 1, 3, '1), 1, lpkc_pkg::ORDER_LT,
                                  lpkc_pkg::CAUSE_INFINITE));
        dir_rows.push_back(mk_row(start_item(1, 1, 0, 0), 1, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(start_item(1, 1, 0, 16'hFFFE), 1, lpkc_pkg::ORDER_LT,
                                  lpkc_pkg::CAUSE_LENGTH));
        dir_rows.push_back(mk_row(start_item(1, 1, 16'hFFFE, 0), 1, lpkc_pkg::ORDER_GT,
                                  lpkc_pkg::CAUSE_LENGTH));
        // pair while idle is dropped
        dir_rows.push_back(mk_row(pair_item(8'h01, 8'h02, 1), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        // difference sticks through later pairs
        dir_rows.push_back(mk_row(start_item(1, 1, 3, 3), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(pair_item(8'h00, 8'h00, 0), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(pair_item(8'hFF, 8'h00, 0), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(pair_item(8'h00, 8'hFF, 1), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        // equal bytes, length decides
        dir_rows.push_back(mk_row(start_item(1, 1, 2, 5), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(pair_item(8'hFF, 8'hFF, 0), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(pair_item(8'h00, 8'h00, 1), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        // restart while a comparison is open
        dir_rows.push_back(mk_row(start_item(1, 1, 4, 4), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(pair_item(8'h07, 8'h08, 0), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(start_item(1, 1, 1, 1), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(pair_item(8'h10, 8'h80, 1), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        // last flag ends the comparison regardless of pair count
        dir_rows.push_back(mk_row(start_item(1, 1, 16'hFFFE, 16'hFFFE), 0,
                                  lpkc_pkg::ORDER_EQ, lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(pair_item(8'hAB, 8'hAB, 1), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(start_item(1, 1, 9, 1), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));
        dir_rows.push_back(mk_row(pair_item(8'h80, 8'h80, 1), 0, lpkc_pkg::ORDER_EQ,
                                  lpkc_pkg::CAUSE_EQUAL));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

        while (items_sent < 2000) begin
            if (!hold_done && items_sent >= 400) begin
                hold_done     = 1'b1;
                sink_hold_req = 1'b1;
            end
            if (items_sent >= 1000 && items_sent < 1300) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = 29;
                sink_idle_pct = 29;
            end

            kind = $urandom_range(99);
            if (kind < 70) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
                la = LW'(n);
                lb = LW'(n);
                case ($urandom_range(2))
                    1: begin
                        lb = LW'(n + (($urandom_range(3) == 0) ? $urandom_range(16'hFFFE - n, 1)
                                                               : $urandom_range(3, 1)));
                    end
                    2: begin
                        la = LW'(n + (($urandom_range(3) == 0) ? $urandom_range(16'hFFFE - n, 1)
                                                               : $urandom_range(3, 1)));
                    end
                    default: ;
                endcase
                diff_at = $urandom_range(1) ? $urandom_range(n - 1) : n;
                send_item(start_item(1, 1, la, lb), 1'b0, '0);
                for (k = 0; k < n; k++) begin
                    ba = 8'($urandom);
                    if (k < diff_at)
                        bb = ba;
                    else if (k == diff_at)
                        bb = ba ^ 8'($urandom_range(255, 1));
                    else
                        bb = $urandom_range(1) ? ba : 8'($urandom);
                    send_item(pair_item(ba, bb, k == n - 1), 1'b0, '0);
                end
                items_sent += n + 1;
            end else if (kind < 80) begin
                la = ($urandom_range(3) == 0) ? '1 : LW'($urandom);
                lb = ($urandom_range(3) == 0) ? '1 : LW'($urandom);
                send_item(start_item($urandom_range(1), $urandom_range(1), la, lb), 1'b0, '0);
                items_sent++;
            end else if (kind < 88) begin
                send_item(pair_item($urandom, $urandom, $urandom_range(1)), 1'b0, '0);
                items_sent++;
            end else begin
                // cut short or ended early; the next start drops whatever is open
                la = LW'($urandom_range(10, 2));
                lb = LW'($urandom_range(10, 2));
                n  = $urandom_range(((la < lb) ? la : lb) - 1, 1);
                send_item(start_item(1, 1, la, lb), 1'b0, '0);
                for (k = 0; k < n; k++) begin
                    ba = 8'($urandom);
                    bb = $urandom_range(2) ? ba : 8'($urandom);
                    send_item(pair_item(ba, bb, (k == n - 1) && $urandom_range(1)), 1'b0, '0);
                end
                items_sent += n + 1;
            end
        end
        i_s_tvalid <= 1'b0;
        src_idle_pct  = 29;
        sink_idle_pct = 29;

        while (order_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_cnt == 0 && order_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
